// File: rtl/vht_pkg.sv
// vht_pkg: shared constants for the vote history table
// used by vote_history_table_unit and its testbench
`timescale 1ns / 1ps

package vht_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int ID_BITS_DEF     = 64;
    localparam int HANDLE_BITS_DEF = 16;

    // longest list answered by one query
    localparam int MAX_OUT = 64;

    localparam logic [5:0] MAX_ENTRIES_RST = 6'd63;

    localparam logic [2:0] FUNC_ADD        = 3'd0;
    localparam logic [2:0] FUNC_ERASE      = 3'd1;
    localparam logic [2:0] FUNC_LIST_ROOT  = 3'd2;
    localparam logic [2:0] FUNC_LIST_HASH  = 3'd3;
    localparam logic [2:0] FUNC_EXISTS     = 3'd4;

endpackage

// File: rtl/vote_history_table_unit.sv
// vote_history_table_unit: insertion-ordered vote table kept packed in one ram
// depends on vht_pkg and vht_ram
//
//   channel   signals                                              direction
//   in        in_valid, in_stall, func .. final_only                 in / stall out
//   out       out_valid, out_stall, out_ref, hit, added, entry_count, last  out / stall in
//   config    max_entries_wen, max_entries                           in
//
// every defined operation scans the packed slots one per cycle through the ram
// read port, unless a list match waits on a stalled output; the unused codes
// skip the scan and go straight to the result.
// compaction (evict, drop, erase) writes slot w while slot i >= w is read.
// reset empties the table at once; no clearing pass.
// in_stall is high from an accepted transfer until its last result is loaded.
`timescale 1ns / 1ps

module vote_history_table_unit #(
    parameter int DEPTH       = vht_pkg::DEPTH_DEF,
    parameter int ID_BITS     = vht_pkg::ID_BITS_DEF,
    parameter int HANDLE_BITS = vht_pkg::HANDLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        max_entries_wen,
    input  logic [5:0]  max_entries,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [63:0] root_id,
    input  logic [63:0] hash_id,
    input  logic [63:0] voter,
    input  logic [63:0] stamp,
    input  logic [15:0] vote_ref,
    input  logic        final_only,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_ref,
    output logic        hit,
    output logic        added,
    output logic [6:0]  entry_count,
    output logic        last
);

    localparam int AW  = $clog2(DEPTH);
    localparam int FW  = $clog2(DEPTH + 1);
    localparam int LW  = (FW > 6) ? FW : 6;
    localparam int IDW = ID_BITS;
    localparam int HW  = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam int EW  = 3 * IDW + 64 + HW;
    localparam int NW  = $clog2(vht_pkg::MAX_OUT + 1);

    localparam int O_STAMP = HW;
    localparam int O_VOTER = HW + 64;
    localparam int O_HASH  = O_VOTER + IDW;
    localparam int O_ROOT  = O_HASH + IDW;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]     max_entries_reg;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [FW-1:0]  drop_reg, drop_next;
    logic [FW-1:0]  rd_idx_reg, rd_idx_next;
    logic [FW-1:0]  chk_idx_reg, chk_idx_next;
    logic           chk_vld_reg, chk_vld_next;
    logic [FW-1:0]  w_reg, w_next;
    logic           store_reg, store_next;
    logic           found_reg, found_next;
    logic           pend_vld_reg, pend_vld_next;
    logic [HW-1:0]  pend_ref_reg, pend_ref_next;
    logic [NW-1:0]  n_reg, n_next;

    logic [2:0]     op_func_reg;
    logic [IDW-1:0] op_root_reg, op_hash_reg, op_voter_reg;
    logic [63:0]    op_stamp_reg;
    logic [HW-1:0]  op_ref_reg;
    logic           op_final_reg;

    logic           out_vld_reg, out_vld_next;
    logic [15:0]    out_ref_reg, out_ref_next;
    logic           hit_reg, hit_next;
    logic           added_reg, added_next;
    logic [6:0]     cnt_reg, cnt_next;
    logic           last_reg, last_next;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr;
    logic [EW-1:0]  ram_wdata, ram_rdata;

    logic           accept, out_free, is_list, done, blocked, lmatch;
    logic           root_eq, hash_eq, voter_eq, keep;
    logic [LW-1:0]  limit;
    logic [FW-1:0]  fill_res;

    vht_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_vld_reg || !out_stall;
    assign out_valid   = out_vld_reg;
    assign out_ref     = out_ref_reg;
    assign hit         = hit_reg;
    assign added       = added_reg;
    assign entry_count = cnt_reg;
    assign last        = last_reg;

    assign is_list  = (op_func_reg == vht_pkg::FUNC_LIST_ROOT) ||
                      (op_func_reg == vht_pkg::FUNC_LIST_HASH);
    assign root_eq  = ram_rdata[O_ROOT +: IDW] == op_root_reg;
    assign hash_eq  = ram_rdata[O_HASH +: IDW] == op_hash_reg;
    assign voter_eq = ram_rdata[O_VOTER +: IDW] == op_voter_reg;

    // list filter for the slot on the read data
    assign lmatch = chk_vld_reg && is_list && root_eq &&
                    ((op_func_reg != vht_pkg::FUNC_LIST_HASH) ||
                     (hash_eq && (!op_final_reg || (&ram_rdata[O_STAMP +: 64]))));
    assign blocked = lmatch && pend_vld_reg && !out_free;
    assign done    = (!chk_vld_reg && (rd_idx_reg >= fill_reg)) ||
                     (is_list && (n_reg == NW'(vht_pkg::MAX_OUT)));

    // eviction keeps at most DEPTH-1 entries
    assign limit = (LW'(max_entries_reg) > LW'(DEPTH - 1)) ? LW'(DEPTH - 1)
                                                           : LW'(max_entries_reg);

    always_comb
    begin
        keep = 1'b1;
        if (op_func_reg == vht_pkg::FUNC_ADD)
        begin
            if (chk_idx_reg < drop_reg)
            begin
                keep = 1'b0;
            end
            else if (root_eq && (!hash_eq ||
                     (voter_eq && (ram_rdata[O_STAMP +: 64] <= op_stamp_reg))))
            begin
                keep = 1'b0;
            end
        end
        else if (root_eq)
        begin
            keep = 1'b0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        drop_next     = drop_reg;
        rd_idx_next   = rd_idx_reg;
        chk_idx_next  = chk_idx_reg;
        chk_vld_next  = chk_vld_reg;
        w_next        = w_reg;
        store_next    = store_reg;
        found_next    = found_reg;
        pend_vld_next = pend_vld_reg;
        pend_ref_next = pend_ref_reg;
        n_next        = n_reg;
        out_vld_next  = out_vld_reg && out_stall;
        out_ref_next  = out_ref_reg;
        hit_next      = hit_reg;
        added_next    = added_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = w_reg[AW-1:0];
        ram_wdata     = ram_rdata;
        fill_res      = fill_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_idx_next   = '0;
                    chk_vld_next  = 1'b0;
                    w_next        = '0;
                    store_next    = 1'b1;
                    found_next    = 1'b0;
                    pend_vld_next = 1'b0;
                    n_next        = '0;
                    drop_next     = (LW'(fill_reg) > limit) ? FW'(LW'(fill_reg) - limit)
                                                            : '0;
                    if (func <= vht_pkg::FUNC_EXISTS)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (done)
                begin
                    state_next = ST_FIN;
                end
                else if (!blocked)
                begin
                    if (chk_vld_reg)
                    begin
                        if ((op_func_reg == vht_pkg::FUNC_ADD) ||
                            (op_func_reg == vht_pkg::FUNC_ERASE))
                        begin
                            if (keep)
                            begin
                                ram_we = 1'b1;
                                w_next = w_reg + 1'b1;
                            end
                            // a newer vote from this voter survives: skip the add
                            if ((op_func_reg == vht_pkg::FUNC_ADD) && keep &&
                                root_eq && voter_eq)
                            begin
                                store_next = 1'b0;
                            end
                        end
                        if ((op_func_reg == vht_pkg::FUNC_EXISTS) && root_eq)
                        begin
                            found_next = 1'b1;
                        end
                        if (lmatch)
                        begin
                            // the held match is not the last one: send it
                            if (pend_vld_reg)
                            begin
                                out_vld_next = 1'b1;
                                out_ref_next = 16'(pend_ref_reg);
                                hit_next     = 1'b1;
                                added_next   = 1'b0;
                                last_next    = 1'b0;
                                cnt_next     = (32'(fill_reg) > 32'd127) ? 7'd127
                                                                         : 7'(fill_reg);
                            end
                            pend_vld_next = 1'b1;
                            pend_ref_next = ram_rdata[HW-1:0];
                            n_next        = n_reg + 1'b1;
                        end
                    end
                    if (rd_idx_reg < fill_reg)
                    begin
                        ram_re       = 1'b1;
                        rd_idx_next  = rd_idx_reg + 1'b1;
                        chk_idx_next = rd_idx_reg;
                        chk_vld_next = 1'b1;
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    out_ref_next = '0;
                    hit_next     = 1'b0;
                    added_next   = 1'b0;
                    last_next    = 1'b1;
                    case (op_func_reg)
                        vht_pkg::FUNC_ADD:
                        begin
                            fill_res   = store_reg ? (w_reg + 1'b1) : w_reg;
                            added_next = store_reg;
                            ram_we     = store_reg;
                            ram_wdata  = {op_root_reg, op_hash_reg, op_voter_reg,
                                          op_stamp_reg, op_ref_reg};
                        end
                        vht_pkg::FUNC_ERASE:
                        begin
                            fill_res = w_reg;
                        end
                        vht_pkg::FUNC_LIST_ROOT, vht_pkg::FUNC_LIST_HASH:
                        begin
                            out_ref_next = pend_vld_reg ? 16'(pend_ref_reg) : '0;
                            hit_next     = pend_vld_reg;
                        end
                        vht_pkg::FUNC_EXISTS:
                        begin
                            hit_next = found_reg;
                        end
                        default:
                        begin
                            fill_res = fill_reg;
                        end
                    endcase
                    fill_next  = fill_res;
                    cnt_next   = (32'(fill_res) > 32'd127) ? 7'd127 : 7'(fill_res);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_entries_reg <= vht_pkg::MAX_ENTRIES_RST;
            fill_reg        <= '0;
            chk_vld_reg     <= 1'b0;
            pend_vld_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            chk_vld_reg  <= chk_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            if (max_entries_wen)
            begin
                max_entries_reg <= max_entries;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        drop_reg     <= drop_next;
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        w_reg        <= w_next;
        store_reg    <= store_next;
        found_reg    <= found_next;
        pend_ref_reg <= pend_ref_next;
        n_reg        <= n_next;
        out_ref_reg  <= out_ref_next;
        hit_reg      <= hit_next;
        added_reg    <= added_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        if (accept)
        begin
            op_func_reg  <= func;
            op_root_reg  <= root_id[IDW-1:0];
            op_hash_reg  <= hash_id[IDW-1:0];
            op_voter_reg <= voter[IDW-1:0];
            op_stamp_reg <= stamp;
            op_ref_reg   <= vote_ref[HW-1:0];
            op_final_reg <= final_only;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= DEPTH)
        else $error("fill count beyond table depth");

    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg != ST_IDLE))
        else $error("result loaded while idle");

    a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != ST_IDLE))
        else $error("ram write while idle");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == ST_SCAN)) |-> (w_reg <= chk_idx_reg))
        else $error("compaction write ahead of read");
`endif

endmodule

// File: rtl/vht_ram.sv
// vht_ram: generic single write port memory with a registered read
// no dependencies
`timescale 1ns / 1ps

module vht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
